FILE: rtl/vbap_pkg.sv
// Shared types and constants for the triangle gain selector.
// Holds the sequencer state type, command codes and the matrix slot decode.
// No dependencies.
`timescale 1ns / 1ps

package vbap_pkg;

   // Request command codes.
   localparam logic [1:0] CMD_LOAD_COEF = 2'd0;
   localparam logic [1:0] CMD_LOAD_SPK  = 2'd1;
   localparam logic [1:0] CMD_QUERY     = 2'd2;

   // Width of one row product accumulator and the match threshold in Q.30.
   localparam int unsigned T_W = 42;
   localparam logic signed [T_W-1:0] THRESH_Q30 = -42'sd1073741;

   // Coefficient slots per triangle matrix.
   localparam logic [3:0] SLOTS = 4'd9;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUMSQ,
      S_SQRT,
      S_DIV_LD,
      S_DIV_RUN,
      S_SRCH,
      S_MAT,
      S_CHK,
      S_SHIFT
   } state_type;

   // Row of a row-major matrix slot.
   function automatic logic [1:0] slot_row(input logic [3:0] slot);
      logic [1:0] r;
      unique case (slot) inside
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   // Column of a row-major matrix slot.
   function automatic logic [1:0] slot_col(input logic [3:0] slot);
      logic [1:0] c;
      unique case (slot) inside
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/vbap_triangle_gain_select.sv
// Top level of the speaker triangle selector with gain normalization.
// Holds the triangle memories, the sequencer and the shared arithmetic units.
// Depends on vbap_pkg.
`timescale 1ns / 1ps

// Loads of a coefficient or speaker triple never raise busy. Each triangle of a
// query passes through the single multiplier and the matrix memory port.
// The result strobe rises at the edge where busy falls; the receiver cannot stall.
// Reset is synchronous: it clears the sequencer, the strobe and the triangle count.
module vbap_triangle_gain_select #(
   parameter int unsigned MAX_TRIANGLES = 64,
   parameter int unsigned SPEAKER_BITS  = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_cmd,
   input  logic [5:0]         req_tri_index,
   input  logic [3:0]         req_coef_slot,
   input  logic signed [23:0] req_coef_value,
   input  logic [5:0]         req_spk_first,
   input  logic [5:0]         req_spk_second,
   input  logic [5:0]         req_spk_third,
   input  logic signed [15:0] req_src_x,
   input  logic signed [15:0] req_src_y,
   input  logic signed [15:0] req_src_z,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic [5:0]         rsp_out_spk_first,
   output logic [5:0]         rsp_out_spk_second,
   output logic [5:0]         rsp_out_spk_third,
   output logic signed [15:0] rsp_gain_first,
   output logic signed [15:0] rsp_gain_second,
   output logic signed [15:0] rsp_gain_third
);

   // Address widths follow from the table depth.
   localparam int unsigned AW = $clog2(MAX_TRIANGLES * 9);
   localparam int unsigned IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int unsigned EW = $clog2(MAX_TRIANGLES + 1);
   localparam int unsigned CW = (EW > 7) ? EW : 7;
   localparam int unsigned SW = 3 * SPEAKER_BITS;
   localparam int unsigned TW = vbap_pkg::T_W;

   // Triangle storage. Neither memory is cleared; entries are valid once written.
   logic signed [23:0] mat_mem [MAX_TRIANGLES*9];
   logic [SW-1:0]      spk_mem [MAX_TRIANGLES];

   vbap_pkg::state_type state_ff, state_in;

   logic [6:0]  count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        found_ff, found_in;
   logic [5:0]  ospk_ff [3];
   logic [5:0]  ospk_in [3];
   logic signed [15:0] gout_ff [3];
   logic signed [15:0] gout_in [3];

   logic        gain_mode_ff, gain_mode_in;
   logic [1:0]  kidx_ff, kidx_in;
   logic [4:0]  step_ff, step_in;
   logic signed [15:0] src_ff [3];
   logic signed [15:0] src_in [3];
   logic [63:0] acc_ff, acc_in;
   logic [63:0] sq_v_ff, sq_v_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [31:0] len_ff, len_in;
   logic [46:0] dv_num_ff, dv_num_in, dv_den_ff, dv_den_in;
   logic [15:0] dv_q_ff, dv_q_in;
   logic signed [15:0] n_ff [3];
   logic signed [15:0] n_in [3];
   logic signed [15:0] g_ff [3];
   logic signed [15:0] g_in [3];

   logic [EW-1:0] entry_ff, entry_in;
   logic [AW-1:0] base_ff, base_in;
   logic [3:0]    issue_ff, issue_in;
   logic          v1_ff, v1_in, v2_ff, v2_in;
   logic [3:0]    s1_ff, s1_in, s2_ff, s2_in;
   logic signed [23:0] rd_ff;
   logic [SW-1:0]      spk_rd_ff;
   logic signed [63:0] prod_ff;
   logic signed [TW-1:0] t_ff [3];
   logic signed [TW-1:0] t_in [3];
   logic [TW-1:0] tmag_ff [3];
   logic [TW-1:0] tmag_in [3];
   logic          tneg_ff [3];
   logic          tneg_in [3];

   // Request decode.
   logic          accept;
   logic          tri_ok;
   logic [9:0]    wsum;
   logic [AW-1:0] rd_addr;

   // The one multiplier, shared by the sums of squares and the matrix products.
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;

   assign busy    = (state_ff != vbap_pkg::S_IDLE);
   assign accept  = start && !busy;
   assign tri_ok  = (32'(req_tri_index) < MAX_TRIANGLES);
   assign wsum    = (10'(req_tri_index) * 10'd9) + 10'(req_coef_slot);
   assign rd_addr = base_ff + AW'(issue_ff);

   // Matrix memory: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (accept && req_cmd == vbap_pkg::CMD_LOAD_COEF && tri_ok &&
          req_coef_slot < vbap_pkg::SLOTS) begin
         mat_mem[AW'(wsum)] <= req_coef_value;
      end
      rd_ff <= mat_mem[rd_addr];
   end

   // Speaker memory: the read follows the entry under test.
   always_ff @(posedge clock) begin
      if (accept && req_cmd == vbap_pkg::CMD_LOAD_SPK && tri_ok) begin
         spk_mem[IW'(req_tri_index)] <= {SPEAKER_BITS'(req_spk_first),
                                         SPEAKER_BITS'(req_spk_second),
                                         SPEAKER_BITS'(req_spk_third)};
      end
      spk_rd_ff <= spk_mem[entry_ff[IW-1:0]];
   end

   // Multiplier operand selection. During the sums of squares the step picks
   // the component; during the matrix walk the slot tag picks the column.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == vbap_pkg::S_MAT) begin
         mul_a = 32'(rd_ff);
         mul_b = 32'(n_ff[vbap_pkg::slot_col(s1_ff)]);
      end else if (step_ff < 5'd3) begin
         if (gain_mode_ff) begin
            mul_a = {2'b00, tmag_ff[step_ff[1:0]][29:0]};
         end else begin
            mul_a = 32'(src_ff[step_ff[1:0]]);
         end
         mul_b = mul_a;
      end
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      logic [63:0] trial;
      logic [63:0] res_nx;
      logic [46:0] num_nx;
      logic [15:0] q_nx;
      logic [15:0] mag;
      logic        neg;
      logic        ok;
      logic        big;
      logic        lim_hit;

      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      found_in     = found_ff;
      ospk_in      = ospk_ff;
      gout_in      = gout_ff;
      gain_mode_in = gain_mode_ff;
      kidx_in      = kidx_ff;
      step_in      = step_ff;
      src_in       = src_ff;
      acc_in       = acc_ff;
      sq_v_in      = sq_v_ff;
      sq_res_in    = sq_res_ff;
      sq_bit_in    = sq_bit_ff;
      len_in       = len_ff;
      dv_num_in    = dv_num_ff;
      dv_den_in    = dv_den_ff;
      dv_q_in      = dv_q_ff;
      n_in         = n_ff;
      g_in         = g_ff;
      entry_in     = entry_ff;
      base_in      = base_ff;
      issue_in     = issue_ff;
      v1_in        = 1'b0;
      v2_in        = 1'b0;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      t_in         = t_ff;
      tmag_in      = tmag_ff;
      tneg_in      = tneg_ff;

      trial   = sq_res_ff + sq_bit_ff;
      res_nx  = '0;
      num_nx  = '0;
      q_nx    = '0;
      mag     = '0;
      neg     = 1'b0;
      ok      = 1'b1;
      big     = 1'b0;
      lim_hit = (CW'(entry_ff) >= CW'(count_ff)) ||
                (CW'(entry_ff) >= CW'(MAX_TRIANGLES));

      if (csr_wr_en) begin
         count_in = csr_wr_data;
      end

      unique case (state_ff)
         vbap_pkg::S_IDLE: begin
            if (accept && req_cmd == vbap_pkg::CMD_QUERY) begin
               src_in[0]    = req_src_x;
               src_in[1]    = req_src_y;
               src_in[2]    = req_src_z;
               gain_mode_in = 1'b0;
               step_in      = '0;
               acc_in       = '0;
               state_in     = vbap_pkg::S_SUMSQ;
            end
         end

         // Sum of three squares: products issue on steps 0..2, are registered and
         // are added on steps 1..3.
         vbap_pkg::S_SUMSQ: begin
            if (step_ff != 5'd0) begin
               acc_in = acc_ff + $unsigned(prod_ff);
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd3) begin
               sq_res_in = '0;
               sq_bit_in = 64'd1 << 62;
               if (gain_mode_ff) begin
                  sq_v_in  = acc_in;
                  state_in = vbap_pkg::S_SQRT;
               end else if (acc_in == 64'd0) begin
                  // A zero source gives an empty result.
                  rsp_valid_in = 1'b1;
                  found_in     = 1'b0;
                  ospk_in      = '{default: '0};
                  gout_in      = '{default: '0};
                  state_in     = vbap_pkg::S_IDLE;
               end else begin
                  sq_v_in  = acc_in << 28;
                  state_in = vbap_pkg::S_SQRT;
               end
            end
         end

         // Integer square root, two radicand bits per step.
         vbap_pkg::S_SQRT: begin
            if (sq_v_ff >= trial) begin
               sq_v_in = sq_v_ff - trial;
               res_nx  = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               res_nx  = sq_res_ff >> 1;
            end
            sq_res_in = res_nx;
            sq_bit_in = sq_bit_ff >> 2;
            if (sq_bit_ff == 64'd1) begin
               len_in  = res_nx[31:0];
               kidx_in = '0;
               if (gain_mode_ff && res_nx == 64'd0) begin
                  // All three row sums are zero: the entry still wins with zero gains.
                  rsp_valid_in = 1'b1;
                  found_in     = 1'b1;
                  ospk_in[0]   = 6'(spk_rd_ff[SW-1 -: SPEAKER_BITS]);
                  ospk_in[1]   = 6'(spk_rd_ff[2*SPEAKER_BITS-1 -: SPEAKER_BITS]);
                  ospk_in[2]   = 6'(spk_rd_ff[SPEAKER_BITS-1:0]);
                  gout_in      = '{default: '0};
                  state_in     = vbap_pkg::S_IDLE;
               end else begin
                  state_in = vbap_pkg::S_DIV_LD;
               end
            end
         end

         // Rounded division: the dividend carries half the divisor so the
         // truncating quotient rounds to nearest.
         vbap_pkg::S_DIV_LD: begin
            if (gain_mode_ff) begin
               dv_num_in = (47'(tmag_ff[kidx_ff][29:0]) << 14) + 47'(len_ff[31:1]);
            end else begin
               mag       = src_ff[kidx_ff][15] ? 16'(-src_ff[kidx_ff])
                                               : 16'(src_ff[kidx_ff]);
               dv_num_in = (47'(mag) << 28) + 47'(len_ff[31:1]);
            end
            dv_den_in = 47'(len_ff) << 15;
            dv_q_in   = '0;
            step_in   = 5'd15;
            state_in  = vbap_pkg::S_DIV_RUN;
         end

         vbap_pkg::S_DIV_RUN: begin
            if (dv_num_ff >= dv_den_ff) begin
               num_nx = dv_num_ff - dv_den_ff;
               q_nx   = {dv_q_ff[14:0], 1'b1};
            end else begin
               num_nx = dv_num_ff;
               q_nx   = {dv_q_ff[14:0], 1'b0};
            end
            dv_num_in = num_nx;
            dv_q_in   = q_nx;
            dv_den_in = dv_den_ff >> 1;
            step_in   = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               neg = gain_mode_ff ? tneg_ff[kidx_ff] : src_ff[kidx_ff][15];
               if (gain_mode_ff) begin
                  g_in[kidx_ff] = neg ? -$signed(q_nx) : $signed(q_nx);
               end else begin
                  n_in[kidx_ff] = neg ? -$signed(q_nx) : $signed(q_nx);
               end
               kidx_in  = kidx_ff + 2'd1;
               state_in = vbap_pkg::S_DIV_LD;
               if (kidx_ff == 2'd2) begin
                  if (gain_mode_ff) begin
                     rsp_valid_in = 1'b1;
                     found_in     = 1'b1;
                     ospk_in[0]   = 6'(spk_rd_ff[SW-1 -: SPEAKER_BITS]);
                     ospk_in[1]   = 6'(spk_rd_ff[2*SPEAKER_BITS-1 -: SPEAKER_BITS]);
                     ospk_in[2]   = 6'(spk_rd_ff[SPEAKER_BITS-1:0]);
                     gout_in[0]   = g_ff[0];
                     gout_in[1]   = g_ff[1];
                     gout_in[2]   = neg ? -$signed(q_nx) : $signed(q_nx);
                     state_in     = vbap_pkg::S_IDLE;
                  end else begin
                     entry_in = '0;
                     base_in  = '0;
                     state_in = vbap_pkg::S_SRCH;
                  end
               end
            end
         end

         vbap_pkg::S_SRCH: begin
            if (lim_hit) begin
               rsp_valid_in = 1'b1;
               found_in     = 1'b0;
               ospk_in      = '{default: '0};
               gout_in      = '{default: '0};
               state_in     = vbap_pkg::S_IDLE;
            end else begin
               t_in     = '{default: '0};
               issue_in = '0;
               state_in = vbap_pkg::S_MAT;
            end
         end

         // Matrix walk: read, multiply and accumulate overlap by one slot each.
         vbap_pkg::S_MAT: begin
            if (issue_ff < vbap_pkg::SLOTS) begin
               v1_in    = 1'b1;
               s1_in    = issue_ff;
               issue_in = issue_ff + 4'd1;
            end
            v2_in = v1_ff;
            s2_in = s1_ff;
            if (v2_ff) begin
               t_in[vbap_pkg::slot_row(s2_ff)] = t_ff[vbap_pkg::slot_row(s2_ff)] +
                                                 prod_ff[TW-1:0];
            end
            if (issue_ff == vbap_pkg::SLOTS && !v1_ff && !v2_ff) begin
               state_in = vbap_pkg::S_CHK;
            end
         end

         vbap_pkg::S_CHK: begin
            for (int k = 0; k < 3; k++) begin
               if (t_ff[k] < vbap_pkg::THRESH_Q30) begin
                  ok = 1'b0;
               end
               tneg_in[k] = t_ff[k][TW-1];
               tmag_in[k] = t_ff[k][TW-1] ? TW'(-t_ff[k]) : TW'(t_ff[k]);
            end
            if (ok) begin
               state_in = vbap_pkg::S_SHIFT;
            end else begin
               entry_in = entry_ff + EW'(1);
               base_in  = base_ff + AW'(9);
               state_in = vbap_pkg::S_SRCH;
            end
         end

         // Shift all magnitudes right together until the largest fits 30 bits.
         vbap_pkg::S_SHIFT: begin
            for (int k = 0; k < 3; k++) begin
               if (tmag_ff[k][TW-1:30] != '0) begin
                  big = 1'b1;
               end
            end
            if (big) begin
               for (int k = 0; k < 3; k++) begin
                  tmag_in[k] = tmag_ff[k] >> 1;
               end
            end else begin
               gain_mode_in = 1'b1;
               step_in      = '0;
               acc_in       = '0;
               state_in     = vbap_pkg::S_SUMSQ;
            end
         end

         default: begin
            state_in = vbap_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vbap_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      ospk_ff      <= ospk_in;
      gout_ff      <= gout_in;
      gain_mode_ff <= gain_mode_in;
      kidx_ff      <= kidx_in;
      step_ff      <= step_in;
      src_ff       <= src_in;
      acc_ff       <= acc_in;
      sq_v_ff      <= sq_v_in;
      sq_res_ff    <= sq_res_in;
      sq_bit_ff    <= sq_bit_in;
      len_ff       <= len_in;
      dv_num_ff    <= dv_num_in;
      dv_den_ff    <= dv_den_in;
      dv_q_ff      <= dv_q_in;
      n_ff         <= n_in;
      g_ff         <= g_in;
      entry_ff     <= entry_in;
      base_ff      <= base_in;
      issue_ff     <= issue_in;
      s1_ff        <= s1_in;
      s2_ff        <= s2_in;
      prod_ff      <= mul_p;
      t_ff         <= t_in;
      tmag_ff      <= tmag_in;
      tneg_ff      <= tneg_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_out_spk_first  = ospk_ff[0];
   assign rsp_out_spk_second = ospk_ff[1];
   assign rsp_out_spk_third  = ospk_ff[2];
   assign rsp_gain_first     = gout_ff[0];
   assign rsp_gain_second    = gout_ff[1];
   assign rsp_gain_third     = gout_ff[2];

endmodule
